@@ design/best_fit_heap_allocator_defines.svh @@
`ifndef BEST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BFHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bfha_pkg.sv @@
`timescale 1ns / 1ps
package bfha_pkg;

  localparam int unsigned HEAP_BYTES   = 128;
  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned LIST_ENTRIES = 32;

  localparam int unsigned LIST_AW = $clog2(LIST_ENTRIES);
  localparam int unsigned COUNT_W = $clog2(LIST_ENTRIES + 1);
  localparam int unsigned HEAP_AW = $clog2(HEAP_BYTES);
  localparam int unsigned PC_W    = 4;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_FULL   = 2'd2,
    ST_TOOBIG = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    C_ALWAYS    = 4'd0,
    C_IN_VALID  = 4'd1,
    C_IS_FREE   = 4'd2,
    C_TOO_BIG   = 4'd3,
    C_SCAN_LAST = 4'd4,
    C_FOUND     = 4'd5,
    C_FULL      = 4'd6,
    C_BAD_OFF   = 4'd7,
    C_OUT_FREE  = 4'd8
  } cond_e;

  typedef struct packed {
    logic    in_ready;
    logic    scan_clr;
    logic    rd_scan;
    logic    scan_cmp;
    logic    rd_size;
    logic    commit;
    logic    append;
    logic    set_res;
    status_e res_st;
    logic    out_push;
    logic    hold;
    cond_e   cond;
    pc_t     target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic is_free;
    logic too_big;
    logic scan_last;
    logic found;
    logic full;
    logic bad_off;
    logic out_free;
  } flags_t;

endpackage

@@ design/bfha_sequencer.sv @@
`timescale 1ns / 1ps
`include "best_fit_heap_allocator_defines.svh"
module bfha_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bfha_pkg::flags_t  flags_i,
  output bfha_pkg::ucode_t  uc_o
);

  localparam bfha_pkg::pc_t S_IDLE   = 4'd0;
  localparam bfha_pkg::pc_t S_DISP   = 4'd1;
  localparam bfha_pkg::pc_t S_CHECK  = 4'd2;
  localparam bfha_pkg::pc_t S_SCAN   = 4'd3;
  localparam bfha_pkg::pc_t S_FIT    = 4'd4;
  localparam bfha_pkg::pc_t S_NOFIT  = 4'd5;
  localparam bfha_pkg::pc_t S_TOOBIG = 4'd6;
  localparam bfha_pkg::pc_t S_COMMIT = 4'd7;
  localparam bfha_pkg::pc_t S_FREE0  = 4'd8;
  localparam bfha_pkg::pc_t S_FREE1  = 4'd9;
  localparam bfha_pkg::pc_t S_FREE2  = 4'd10;
  localparam bfha_pkg::pc_t S_OUT    = 4'd11;
  localparam bfha_pkg::pc_t S_FULL   = 4'd12;
  localparam bfha_pkg::pc_t S_IGNORE = 4'd13;

  bfha_pkg::pc_t pc_q, pc_d;
  bfha_pkg::ucode_t uc;
  logic taken;

  function automatic bfha_pkg::ucode_t rom(input bfha_pkg::pc_t pc);
    bfha_pkg::ucode_t w;
    w        = '0;
    w.cond   = bfha_pkg::C_ALWAYS;
    w.res_st = bfha_pkg::ST_OK;
    w.target = S_IDLE;
    case (pc)
      S_IDLE: begin
        w.in_ready = 1'b1;
        w.scan_clr = 1'b1;
        w.cond     = bfha_pkg::C_IN_VALID;
        w.target   = S_DISP;
        w.hold     = 1'b1;
      end
      S_DISP: begin
        w.cond   = bfha_pkg::C_IS_FREE;
        w.target = S_FREE0;
      end
      S_CHECK: begin
        w.rd_scan = 1'b1;
        w.cond    = bfha_pkg::C_TOO_BIG;
        w.target  = S_TOOBIG;
      end
      S_SCAN: begin
        w.rd_scan  = 1'b1;
        w.scan_cmp = 1'b1;
        w.cond     = bfha_pkg::C_SCAN_LAST;
        w.target   = S_FIT;
        w.hold     = 1'b1;
      end
      S_FIT: begin
        w.cond   = bfha_pkg::C_FOUND;
        w.target = S_COMMIT;
      end
      S_NOFIT: begin
        w.set_res = 1'b1;
        w.res_st  = bfha_pkg::ST_NOFIT;
        w.target  = S_OUT;
      end
      S_TOOBIG: begin
        w.set_res = 1'b1;
        w.res_st  = bfha_pkg::ST_TOOBIG;
        w.target  = S_OUT;
      end
      S_COMMIT: begin
        w.commit  = 1'b1;
        w.set_res = 1'b1;
        w.target  = S_OUT;
      end
      S_FREE0: begin
        w.rd_size = 1'b1;
        w.cond    = bfha_pkg::C_FULL;
        w.target  = S_FULL;
      end
      S_FREE1: begin
        w.cond   = bfha_pkg::C_BAD_OFF;
        w.target = S_IGNORE;
      end
      S_FREE2: begin
        w.append  = 1'b1;
        w.set_res = 1'b1;
        w.target  = S_OUT;
      end
      S_OUT: begin
        w.out_push = 1'b1;
        w.cond     = bfha_pkg::C_OUT_FREE;
        w.target   = S_IDLE;
        w.hold     = 1'b1;
      end
      S_FULL: begin
        w.set_res = 1'b1;
        w.res_st  = bfha_pkg::ST_FULL;
        w.target  = S_OUT;
      end
      S_IGNORE: begin
        w.set_res = 1'b1;
        w.target  = S_OUT;
      end
      default: begin
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

  always_comb begin
    uc = rom(pc_q);
    case (uc.cond)
      bfha_pkg::C_ALWAYS:    taken = 1'b1;
      bfha_pkg::C_IN_VALID:  taken = flags_i.in_valid;
      bfha_pkg::C_IS_FREE:   taken = flags_i.is_free;
      bfha_pkg::C_TOO_BIG:   taken = flags_i.too_big;
      bfha_pkg::C_SCAN_LAST: taken = flags_i.scan_last;
      bfha_pkg::C_FOUND:     taken = flags_i.found;
      bfha_pkg::C_FULL:      taken = flags_i.full;
      bfha_pkg::C_BAD_OFF:   taken = flags_i.bad_off;
      bfha_pkg::C_OUT_FREE:  taken = flags_i.out_free;
      default:               taken = 1'b1;
    endcase
    if (taken) begin
      pc_d = uc.target;
    end else if (uc.hold) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign uc_o = uc;

  `BFHA_ASSERT_NEXT(a_out_to_idle, pc_q == S_OUT && flags_i.out_free, pc_q == S_IDLE, "result step did not return to idle")
  `BFHA_ASSERT_NEXT(a_scan_loops, pc_q == S_SCAN && !flags_i.scan_last, pc_q == S_SCAN, "scan left before last entry")
  `BFHA_ASSERT_NEXT(a_idle_accept, pc_q == S_IDLE && flags_i.in_valid, pc_q == S_DISP, "transfer not dispatched")

endmodule

@@ design/bfha_datapath.sv @@
`timescale 1ns / 1ps
`include "best_fit_heap_allocator_defines.svh"
module bfha_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bfha_pkg::ucode_t  uc_i,
  output bfha_pkg::flags_t  flags_o,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              opcode_i,
  input  logic [7:0]        request_bytes_i,
  input  logic [7:0]        release_offset_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [7:0]        user_offset_o
);

  logic       op_q;
  logic [7:0] req_q, off_q;

  logic [8:0] total_w, free_s_w;
  logic       too_big_w, bad_off_w;

  logic [15:0] list_mem [bfha_pkg::LIST_ENTRIES];
  logic [15:0] list_rdata_q;
  logic        init0_q;
  logic [7:0]  ent_start_w, ent_len_w;

  logic [7:0]  size_mem [bfha_pkg::HEAP_BYTES];
  logic [7:0]  size_rdata_q;

  logic [bfha_pkg::LIST_AW-1:0] idx_q, cmp_q, best_q;
  logic                         found_q;
  logic [7:0]                   best_start_q, best_len_q;
  logic                         better_w;
  logic [bfha_pkg::COUNT_W-1:0] count_q;

  logic                         list_we;
  logic [bfha_pkg::LIST_AW-1:0] list_waddr;
  logic [15:0]                  list_wdata;
  logic                         size_we;

  bfha_pkg::status_e res_st_q;
  logic [7:0]        res_off_q;

  logic       out_valid_q, out_free_w, out_load_w;
  logic [1:0] status_q;
  logic [7:0] offset_q;

  // input capture
  always_ff @(posedge clk_i) begin
    if (in_valid_i && uc_i.in_ready) begin
      op_q  <= opcode_i;
      req_q <= request_bytes_i;
      off_q <= release_offset_i;
    end
  end

  assign total_w   = {1'b0, req_q} + 9'(bfha_pkg::HEADER_BYTES);
  assign free_s_w  = {1'b0, off_q} - 9'(bfha_pkg::HEADER_BYTES);
  assign too_big_w = {1'b0, req_q} > 9'(bfha_pkg::HEAP_BYTES);
  assign bad_off_w = ({1'b0, off_q} < 9'(bfha_pkg::HEADER_BYTES))
                  || (free_s_w >= 9'(bfha_pkg::HEAP_BYTES));

  // free list: start in the upper byte, length in the lower
  always_comb begin
    list_we    = uc_i.commit || uc_i.append;
    list_waddr = uc_i.commit ? best_q : count_q[bfha_pkg::LIST_AW-1:0];
    if (uc_i.commit) begin
      list_wdata = {best_start_q + total_w[7:0], best_len_q - total_w[7:0]};
    end else begin
      list_wdata = {free_s_w[7:0], size_rdata_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_mem[list_waddr] <= list_wdata;
    end
    if (uc_i.rd_scan) begin
      list_rdata_q <= list_mem[idx_q];
    end
  end

  // entry 0 spans the heap until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init0_q <= 1'b1;
    end else if (list_we && list_waddr == '0) begin
      init0_q <= 1'b0;
    end
  end

  always_comb begin
    if (init0_q && cmp_q == '0) begin
      ent_start_w = 8'd0;
      ent_len_w   = 8'(bfha_pkg::HEAP_BYTES);
    end else begin
      ent_start_w = list_rdata_q[15:8];
      ent_len_w   = list_rdata_q[7:0];
    end
  end

  // block size store, indexed by block start
  assign size_we = uc_i.commit && ({1'b0, best_start_q} < 9'(bfha_pkg::HEAP_BYTES));

  always_ff @(posedge clk_i) begin
    if (size_we) begin
      size_mem[best_start_q[bfha_pkg::HEAP_AW-1:0]] <= total_w[7:0];
    end
    if (uc_i.rd_size) begin
      size_rdata_q <= size_mem[free_s_w[bfha_pkg::HEAP_AW-1:0]];
    end
  end

  // best-fit scan, first on ties
  assign better_w = ({1'b0, ent_len_w} >= total_w) && (!found_q || ent_len_w < best_len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      cmp_q   <= '0;
      found_q <= 1'b0;
      count_q <= bfha_pkg::COUNT_W'(1);
    end else begin
      if (uc_i.scan_clr) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else if (uc_i.rd_scan) begin
        idx_q <= idx_q + bfha_pkg::LIST_AW'(1);
      end
      if (uc_i.rd_scan) begin
        cmp_q <= idx_q;
      end
      if (uc_i.scan_cmp && better_w) begin
        found_q <= 1'b1;
      end
      if (uc_i.append) begin
        count_q <= count_q + bfha_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (uc_i.scan_cmp && better_w) begin
      best_q       <= cmp_q;
      best_start_q <= ent_start_w;
      best_len_q   <= ent_len_w;
    end
  end

  // result staging
  always_ff @(posedge clk_i) begin
    if (uc_i.set_res) begin
      res_st_q  <= uc_i.res_st;
      res_off_q <= uc_i.commit ? best_start_q + 8'(bfha_pkg::HEADER_BYTES) : 8'd0;
    end
  end

  // output register
  assign out_free_w = !out_valid_q || out_ready_i;
  assign out_load_w = uc_i.out_push && out_free_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load_w) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load_w) begin
      status_q <= res_st_q;
      offset_q <= res_off_q;
    end
  end

  always_comb begin
    flags_o.in_valid  = in_valid_i;
    flags_o.is_free   = op_q;
    flags_o.too_big   = too_big_w;
    flags_o.scan_last = bfha_pkg::COUNT_W'(cmp_q) == count_q - bfha_pkg::COUNT_W'(1);
    flags_o.found     = found_q;
    flags_o.full      = count_q >= bfha_pkg::COUNT_W'(bfha_pkg::LIST_ENTRIES);
    flags_o.bad_off   = bad_off_w;
    flags_o.out_free  = out_free_w;
  end

  assign in_ready_o    = uc_i.in_ready;
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign user_offset_o = offset_q;

  `BFHA_ASSERT_NOW(a_append_room, uc_i.append, count_q < bfha_pkg::COUNT_W'(bfha_pkg::LIST_ENTRIES), "append into full list")
  `BFHA_ASSERT_NOW(a_commit_found, uc_i.commit, found_q, "commit without a candidate")
  `BFHA_ASSERT_NEXT(a_commit_count, uc_i.commit, $stable(count_q), "allocate changed entry count")

endmodule

@@ design/best_fit_heap_allocator.sv @@
`timescale 1ns / 1ps
// channel   direction  handshake               payload
// in        input      in_valid_i / in_ready_o   opcode_i, request_bytes_i, release_offset_i
// out       output     out_valid_o / out_ready_i status_o, user_offset_o
//
// allocate: oversize check, a scan of every free-list entry, then commit or a no-fit result
// free: size read, full-list check, offset check, append; the scan reads one entry per cycle
// one item at a time; a new item is taken once the sequencer is back at its first step
// a waiting result sits in the output register; the sequencer holds until it is free
// reset clears control state only; entry 0 reads as the whole heap until first written
module best_fit_heap_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       opcode_i,
  input  logic [7:0] request_bytes_i,
  input  logic [7:0] release_offset_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [7:0] user_offset_o
);

  bfha_pkg::ucode_t uc;
  bfha_pkg::flags_t flags;

  bfha_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .uc_o    (uc)
  );

  bfha_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .uc_i             (uc),
    .flags_o          (flags),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .request_bytes_i  (request_bytes_i),
    .release_offset_i (release_offset_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .user_offset_o    (user_offset_o)
  );

endmodule

@@ sim/best_fit_heap_allocator_checker.sv @@
`timescale 1ns / 1ps
module best_fit_heap_allocator_checker
  import bfha_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  is_free_i,
  input  logic [7:0]            request_bytes_i,
  input  logic [7:0]            release_offset_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [1:0]            status_i,
  input  logic [7:0]            user_offset_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output logic [HEAP_BYTES-1:0] size_written_o
);

  typedef struct packed {
    status_e    status;
    logic [7:0] offset;
  } heap_result_t;

  logic [7:0]   hole_start [LIST_ENTRIES];
  logic [7:0]   hole_len   [LIST_ENTRIES];
  int           hole_count;
  logic [7:0]   block_size [HEAP_BYTES];
  heap_result_t awaited_results [$];

  task automatic predict_heap_op(input logic is_free, input logic [7:0] req,
                                 input logic [7:0] rel, output heap_result_t res);
    int need;
    int best;
    int s;
    int r;
    bit found;
    res.status = ST_OK;
    res.offset = '0;
    if (!is_free) begin
      if (int'(req) > HEAP_BYTES) begin
        res.status = ST_TOOBIG;
      end else begin
        need  = int'(req) + HEADER_BYTES;
        found = 1'b0;
        best  = 0;
        for (int i = 0; i < hole_count && i < LIST_ENTRIES; i++) begin
          if (int'(hole_len[i]) >= need && (!found || hole_len[i] < hole_len[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          res.status = ST_NOFIT;
        end else begin
          s = int'(hole_start[best]);
          if (s < HEAP_BYTES) begin
            block_size[s]     = 8'(need);
            size_written_o[s] = 1'b1;
          end
          hole_start[best] = 8'(s + need);
          hole_len[best]   = 8'(int'(hole_len[best]) - need);
          res.offset       = 8'(s + HEADER_BYTES);
        end
      end
    end else begin
      r = int'(rel);
      if (hole_count >= LIST_ENTRIES) begin
        res.status = ST_FULL;
      end else if (r >= HEADER_BYTES && r - HEADER_BYTES < HEAP_BYTES) begin
        s                      = r - HEADER_BYTES;
        hole_start[hole_count] = 8'(s);
        hole_len[hole_count]   = block_size[s];
        hole_count++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    heap_result_t want;
    heap_result_t fresh;
    if (!rst_ni) begin
      for (int i = 0; i < LIST_ENTRIES; i++) begin
        hole_start[i] = '0;
        hole_len[i]   = '0;
      end
      hole_len[0] = 8'(HEAP_BYTES);
      hole_count  = 1;
      for (int i = 0; i < HEAP_BYTES; i++) block_size[i] = '0;
      size_written_o = '0;
      awaited_results.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          if (fail_count_o < 10)
            $display("unexpected result: status %0d offset %0d", status_i, user_offset_i);
          fail_count_o++;
        end else begin
          want = awaited_results.pop_front();
          if (status_e'(status_i) != want.status || user_offset_i != want.offset) begin
            if (fail_count_o < 10)
              $display("mismatch at %0t: status exp %0d got %0d, offset exp %0d got %0d",
                       $realtime, want.status, status_i, want.offset, user_offset_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_heap_op(is_free_i, request_bytes_i, release_offset_i, fresh);
        awaited_results.push_back(fresh);
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import bfha_pkg::*;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;
  localparam int   IDLE_LIMIT = 2000;
  localparam int   RANDOM_ITEMS = 450;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       opcode_i;
  logic [7:0] request_bytes_i;
  logic [7:0] release_offset_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [1:0] status_o;
  logic [7:0] user_offset_o;

  int                    fail_count;
  int                    pending;
  logic [HEAP_BYTES-1:0] size_written;
  bit                    no_idle;

  best_fit_heap_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .request_bytes_i (request_bytes_i),
    .release_offset_i(release_offset_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .user_offset_o   (user_offset_o)
  );

  best_fit_heap_allocator_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .is_free_i       (opcode_i),
    .request_bytes_i (request_bytes_i),
    .release_offset_i(release_offset_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_i        (status_o),
    .user_offset_i   (user_offset_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .size_written_o  (size_written)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // called and left at a falling edge
  task automatic send_item(input logic op, input logic [7:0] req, input logic [7:0] rel);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    opcode_i         = op;
    request_bytes_i  = req;
    release_offset_i = rel;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic int pick_live_offset();
    int base;
    int idx;
    base = $urandom_range(0, HEAP_BYTES - 1);
    for (int k = 0; k < HEAP_BYTES; k++) begin
      idx = (base + k) % HEAP_BYTES;
      if (size_written[idx]) return idx + HEADER_BYTES;
    end
    return -1;
  endfunction

  function automatic logic [7:0] pick_bad_offset();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, HEADER_BYTES - 1));
    return 8'($urandom_range(HEAP_BYTES + HEADER_BYTES, 255));
  endfunction

  // receiver side
  initial begin
    int stall;
    out_ready_i = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("best_fit_heap_allocator test failed");
    $finish;
  end

  initial begin
    int counted;
    int sel;
    int live;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    opcode_i         = OP_ALLOC;
    request_bytes_i  = '0;
    release_offset_i = '0;
    no_idle          = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: limits, bad offsets, double free, ties and emptied entries
    send_item(OP_ALLOC, 8'd0, 8'hff);
    send_item(OP_ALLOC, 8'd128, 8'h00);
    send_item(OP_ALLOC, 8'd129, 8'h00);
    send_item(OP_ALLOC, 8'd255, 8'h00);
    send_item(OP_FREE, 8'hff, 8'd0);
    send_item(OP_FREE, 8'h00, 8'd3);
    send_item(OP_FREE, 8'h00, 8'd132);
    send_item(OP_FREE, 8'h00, 8'd255);
    send_item(OP_FREE, 8'h00, 8'd4);
    send_item(OP_FREE, 8'h00, 8'd4);
    send_item(OP_ALLOC, 8'd0, 8'h00);
    send_item(OP_ALLOC, 8'd0, 8'h00);
    send_item(OP_ALLOC, 8'd8, 8'h00);
    send_item(OP_ALLOC, 8'd16, 8'h00);
    send_item(OP_FREE, 8'h00, 8'd8);
    send_item(OP_ALLOC, 8'd5, 8'h00);
    send_item(OP_FREE, 8'h00, 8'd20);
    send_item(OP_ALLOC, 8'd124, 8'h00);
    send_item(OP_ALLOC, 8'd15, 8'h00);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      sel  = $urandom_range(0, 99);
      live = pick_live_offset();
      if (sel < 50) begin
        send_item(OP_ALLOC, 8'($urandom_range(0, 24)), 8'($urandom));
        counted++;
      end else if (sel < 65) begin
        send_item(OP_ALLOC, 8'($urandom_range(0, 255)), 8'($urandom));
        counted++;
      end else if (sel < 72) begin
        send_item(OP_ALLOC, 8'($urandom_range(100, 130)), 8'($urandom));
        counted++;
      end else if (sel < 90 && live >= 0) begin
        send_item(OP_FREE, 8'($urandom), 8'(live));
        counted++;
      end else if (sel < 90) begin
        send_item(OP_ALLOC, 8'($urandom_range(0, 24)), 8'($urandom));
        counted++;
      end else begin
        send_item(OP_FREE, 8'($urandom), pick_bad_offset());
        counted++;
      end
    end

    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("best_fit_heap_allocator test passed");
    end else begin
      $display("best_fit_heap_allocator test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/bfha_pkg.sv
design/bfha_sequencer.sv
design/bfha_datapath.sv
design/best_fit_heap_allocator.sv
sim/best_fit_heap_allocator_checker.sv
sim/testbench.sv
